// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers used by the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/picd_pkg.sv =====
package picd_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned MnemWidth  = 7;
   localparam int unsigned XoWidth    = 10;
   localparam int unsigned PrimWidth  = 6;

   // Mnemonic index, in listing order.
   typedef enum logic [MnemWidth-1:0] {
      MN_PSQ_STX = 7'd0, MN_SUBFIC, MN_CMPLI, MN_CMPI, MN_ADDIC, MN_ADDIC_RC,
      MN_ADDI, MN_ADDIS, MN_BC, MN_B, MN_BCLR, MN_CRXOR, MN_CROR, MN_BCCTR,
      MN_RLWIMI, MN_RLWINM, MN_ORI, MN_ORIS, MN_XORIS, MN_CMP, MN_SLW, MN_SUBF,
      MN_MFSPR, MN_OR, MN_MTSPR, MN_SRW, MN_EXTSB, MN_NEG, MN_LWZ, MN_LWZU,
      MN_LBZ, MN_STW, MN_STWU, MN_STB, MN_LHZ, MN_STH, MN_LMW, MN_STMW, MN_LFS,
      MN_LFSU, MN_LFD, MN_STFS, MN_STFSU, MN_STFD, MN_PSQ_L, MN_FDIVS, MN_FSUBS,
      MN_FADDS, MN_FMULS, MN_FMSUBS, MN_FMADDS, MN_FNMSUBS, MN_PSQ_ST, MN_FRSP,
      MN_FCTIWZ, MN_FCMPO, MN_FNEG, MN_FMR, MN_FABS, MN_FDIV, MN_FSUB, MN_FADD,
      MN_FSEL, MN_FMUL, MN_FRSQRTE, MN_FMSUB, MN_FMADD, MN_FNMSUB, MN_UNKNOWN
   } mnem_type;

   // Which extended-opcode group a primary opcode refers to.
   typedef enum logic [2:0] {
      GRP_NONE = 3'd0,
      GRP_19   = 3'd1,
      GRP_31   = 3'd2,
      GRP_59   = 3'd3,
      GRP_63   = 3'd4
   } grp_type;

   localparam logic [PrimWidth-1:0] OpGroup19 = 6'd19;
   localparam logic [PrimWidth-1:0] OpGroup31 = 6'd31;
   localparam logic [PrimWidth-1:0] OpGroup59 = 6'd59;
   localparam logic [PrimWidth-1:0] OpGroup63 = 6'd63;

   localparam logic [8:0] XoNegLow = 9'd104;

   typedef struct packed {
      mnem_type mnem;
      grp_type  grp;
   } prim_dec_type;

   typedef struct packed {
      mnem_type prim_mnem;
      grp_type  grp;
      mnem_type g19;
      mnem_type g31;
      mnem_type g59;
      mnem_type g63;
   } dec_stage_type;

   function automatic prim_dec_type decode_primary(input logic [PrimWidth-1:0] op);
      prim_dec_type d;
      d.grp  = GRP_NONE;
      d.mnem = MN_UNKNOWN;
      unique case (op)
         6'd4:  d.mnem = MN_PSQ_STX;
         6'd8:  d.mnem = MN_SUBFIC;
         6'd10: d.mnem = MN_CMPLI;
         6'd11: d.mnem = MN_CMPI;
         6'd12: d.mnem = MN_ADDIC;
         6'd13: d.mnem = MN_ADDIC_RC;
         6'd14: d.mnem = MN_ADDI;
         6'd15: d.mnem = MN_ADDIS;
         6'd16: d.mnem = MN_BC;
         6'd18: d.mnem = MN_B;
         OpGroup19: d.grp = GRP_19;
         6'd20: d.mnem = MN_RLWIMI;
         6'd21: d.mnem = MN_RLWINM;
         6'd24: d.mnem = MN_ORI;
         6'd25: d.mnem = MN_ORIS;
         6'd27: d.mnem = MN_XORIS;
         OpGroup31: d.grp = GRP_31;
         6'd32: d.mnem = MN_LWZ;
         6'd33: d.mnem = MN_LWZU;
         6'd34: d.mnem = MN_LBZ;
         6'd36: d.mnem = MN_STW;
         6'd37: d.mnem = MN_STWU;
         6'd38: d.mnem = MN_STB;
         6'd40: d.mnem = MN_LHZ;
         6'd44: d.mnem = MN_STH;
         6'd46: d.mnem = MN_LMW;
         6'd47: d.mnem = MN_STMW;
         6'd48: d.mnem = MN_LFS;
         6'd49: d.mnem = MN_LFSU;
         6'd50: d.mnem = MN_LFD;
         6'd52: d.mnem = MN_STFS;
         6'd53: d.mnem = MN_STFSU;
         6'd54: d.mnem = MN_STFD;
         6'd56: d.mnem = MN_PSQ_L;
         OpGroup59: d.grp = GRP_59;
         6'd60: d.mnem = MN_PSQ_ST;
         OpGroup63: d.grp = GRP_63;
         default: d.mnem = MN_UNKNOWN;
      endcase
      return d;
   endfunction

   function automatic mnem_type decode_g19(input logic [XoWidth-1:0] xo);
      mnem_type m;
      unique case (xo)
         10'd16:  m = MN_BCLR;
         10'd193: m = MN_CRXOR;
         10'd449: m = MN_CROR;
         10'd528: m = MN_BCCTR;
         default: m = MN_UNKNOWN;
      endcase
      return m;
   endfunction

   function automatic mnem_type decode_g31(input logic [XoWidth-1:0] xo);
      mnem_type m;
      unique case (xo)
         10'd0:   m = MN_CMP;
         10'd24:  m = MN_SLW;
         10'd40:  m = MN_SUBF;
         10'd339: m = MN_MFSPR;
         10'd444: m = MN_OR;
         10'd467: m = MN_MTSPR;
         10'd536: m = MN_SRW;
         10'd954: m = MN_EXTSB;
         // neg ignores the OE bit
         default: m = (xo[8:0] == XoNegLow) ? MN_NEG : MN_UNKNOWN;
      endcase
      return m;
   endfunction

   function automatic mnem_type decode_g59(input logic [4:0] xo);
      mnem_type m;
      unique case (xo)
         5'd18:   m = MN_FDIVS;
         5'd20:   m = MN_FSUBS;
         5'd21:   m = MN_FADDS;
         5'd25:   m = MN_FMULS;
         5'd28:   m = MN_FMSUBS;
         5'd29:   m = MN_FMADDS;
         5'd30:   m = MN_FNMSUBS;
         default: m = MN_UNKNOWN;
      endcase
      return m;
   endfunction

   function automatic mnem_type decode_g63(input logic [XoWidth-1:0] xo);
      mnem_type m;
      mnem_type m5;
      unique case (xo[4:0])
         5'd18:   m5 = MN_FDIV;
         5'd20:   m5 = MN_FSUB;
         5'd21:   m5 = MN_FADD;
         5'd23:   m5 = MN_FSEL;
         5'd25:   m5 = MN_FMUL;
         5'd26:   m5 = MN_FRSQRTE;
         5'd28:   m5 = MN_FMSUB;
         5'd29:   m5 = MN_FMADD;
         5'd30:   m5 = MN_FNMSUB;
         default: m5 = MN_UNKNOWN;
      endcase
      // full code first, then fall back to the A-form low bits
      unique case (xo)
         10'd12:  m = MN_FRSP;
         10'd15:  m = MN_FCTIWZ;
         10'd32:  m = MN_FCMPO;
         10'd40:  m = MN_FNEG;
         10'd72:  m = MN_FMR;
         10'd264: m = MN_FABS;
         default: m = m5;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/ppc_instruction_class_decoder_unit.sv =====
// Channel  | Direction | Payload
// req_     | in        | tdata[31:0] instr_word
// rsp_     | out       | tdata[6:0] mnemonic, tdata[7] zero; tuser[0] unknown
//
// Three register stages: capture word with its primary decode, decode all
// group tables, select. One transaction per cycle is sustained while
// rsp_tready is high.
// Reset (synchronous, active high) clears the stage valid bits only.
// Each stage advances when the stage after it is empty or moving, so a stall
// on rsp_tready fills bubbles first and then holds every stage in place.
`include "assert_macros.svh"

module ppc_instruction_class_decoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [picd_pkg::WordWidth-1:0]   req_tdata,   // [31:0] instr_word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [6:0] mnemonic, [7] zero
   output logic                             rsp_tuser    // [0] unknown
);
   import picd_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [WordWidth-1:0] s1_word_ff;
   prim_dec_type         s1_prim_ff, s1_prim_in;
   logic                 s2_valid_ff, s2_valid_in;
   dec_stage_type        s2_dec_ff, s2_dec_in;
   logic                 s3_valid_ff, s3_valid_in;
   mnem_type             s3_mnem_ff, s3_mnem_in;

   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready = !s3_valid_ff || rsp_tready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign s1_valid_in = (req_tvalid && s1_ready) || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = (s1_valid_ff && s2_ready) || (s2_valid_ff && !s3_ready);
   assign s3_valid_in = (s2_valid_ff && s3_ready) || (s3_valid_ff && !rsp_tready);

   // Stage 1 decode: primary opcode
   assign s1_prim_in = decode_primary(req_tdata[31:26]);

   // Stage 2 decode: every group table in parallel
   always_comb begin
      s2_dec_in.prim_mnem = s1_prim_ff.mnem;
      s2_dec_in.grp       = s1_prim_ff.grp;
      s2_dec_in.g19       = decode_g19(s1_word_ff[10:1]);
      s2_dec_in.g31       = decode_g31(s1_word_ff[10:1]);
      s2_dec_in.g59       = decode_g59(s1_word_ff[5:1]);
      s2_dec_in.g63       = decode_g63(s1_word_ff[10:1]);
   end

   // Stage 3: pick the group result
   always_comb begin
      unique case (s2_dec_ff.grp)
         GRP_19:  s3_mnem_in = s2_dec_ff.g19;
         GRP_31:  s3_mnem_in = s2_dec_ff.g31;
         GRP_59:  s3_mnem_in = s2_dec_ff.g59;
         GRP_63:  s3_mnem_in = s2_dec_ff.g63;
         GRP_NONE: s3_mnem_in = s2_dec_ff.prim_mnem;
         default: s3_mnem_in = MN_UNKNOWN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         s1_word_ff <= req_tdata;
         s1_prim_ff <= s1_prim_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_dec_ff <= s2_dec_in;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_mnem_ff <= s3_mnem_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {1'b0, s3_mnem_ff};
   assign rsp_tuser  = (s3_mnem_ff == MN_UNKNOWN);

   `ASSERT_HOLDS(a_unknown_flag, clock, reset,
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[6:0] == MN_UNKNOWN)),
      "unknown flag disagrees with mnemonic")
   `ASSERT_NEVER(a_mnem_range, clock, reset,
      rsp_tvalid && (rsp_tdata[6:0] > MN_UNKNOWN),
      "mnemonic index out of range")
   `ASSERT_HOLDS(a_s2_hold, clock, reset,
      (s2_valid_ff && !s3_ready) |=> (s2_valid_ff && $stable(s2_dec_ff)),
      "stage 2 lost or changed its transaction during a stall")
   `ASSERT_HOLDS(a_s1_hold, clock, reset,
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_word_ff)),
      "stage 1 lost or changed its transaction during a stall")

endmodule
